// ===== rtl/core/spc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the skin pixel classifier.
// No dependencies.
package spc_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned CfgAw  = 3;
  localparam int unsigned InDw   = 24;
  localparam int unsigned OutDw  = 8;

  typedef enum logic [CfgAw-1:0] {
    REG_BLUE_MIN  = 3'd0,
    REG_GREEN_MIN = 3'd1,
    REG_RED_MIN   = 3'd2,
    REG_RG_GAP    = 3'd3,
    REG_HUE_MAX   = 3'd4,
    REG_SAT_MIN   = 3'd5,
    REG_SAT_MAX   = 3'd6
  } spc_reg_idx_t;

  localparam logic [PixW-1:0] BlueMinRst  = 8'd20;
  localparam logic [PixW-1:0] GreenMinRst = 8'd40;
  localparam logic [PixW-1:0] RedMinRst   = 8'd95;
  localparam logic [PixW-1:0] RgGapRst    = 8'd15;
  localparam logic [PixW-1:0] HueMaxRst   = 8'd25;
  localparam logic [PixW-1:0] SatMinRst   = 8'd59;
  localparam logic [PixW-1:0] SatMaxRst   = 8'd173;

  // hue offset for negative hues (half degrees)
  localparam logic signed [9:0] HueWrap = 10'sd179;

  typedef struct packed {
    logic [PixW-1:0] blue_min;
    logic [PixW-1:0] green_min;
    logic [PixW-1:0] red_min;
    logic [PixW-1:0] red_green_gap;
    logic [PixW-1:0] hue_max;
    logic [PixW-1:0] sat_min;
    logic [PixW-1:0] sat_max;
  } spc_cfg_t;

endpackage

// ===== rtl/core/spc_datapath.sv =====
`timescale 1ns / 1ps
// Three-stage classification pipeline: RGB rule, products, compares.
// Depends on spc_pkg.
module spc_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      src_valid,
  input  logic [spc_pkg::PixW-1:0]  blue,
  input  logic [spc_pkg::PixW-1:0]  green,
  input  logic [spc_pkg::PixW-1:0]  red,
  input  spc_pkg::spc_cfg_t         cfg,
  output logic                      res_valid,
  output logic                      is_skin
);

  // Only red as maximum can pass, so hue and saturation use mx = red.

  // stage 1
  logic              v1_r, v1_nxt;
  logic              ok1_r, ok1_nxt;
  logic [7:0]        d1_r, d1_nxt;
  logic signed [8:0] n1_r, n1_nxt;
  logic [7:0]        r1_r;
  logic [7:0]        mn;
  logic [8:0]        rg_diff;

  always_comb begin
    mn      = (green < blue) ? green : blue;
    d1_nxt  = red - mn;
    n1_nxt  = $signed({1'b0, green}) - $signed({1'b0, blue});
    rg_diff = {1'b0, red} - {1'b0, green};
    ok1_nxt = (blue >= cfg.blue_min) && (green >= cfg.green_min) &&
              (red >= cfg.red_min) && (red > green) && (red > blue) &&
              (rg_diff > {1'b0, cfg.red_green_gap});
    v1_nxt  = src_valid;
  end

  // stage 2
  logic               v2_r;
  logic               ok2_r;
  logic signed [15:0] x2_r, x2_nxt;
  logic [17:0]        hp2_r, hp2_nxt;
  logic signed [17:0] hn2_r, hn2_nxt;
  logic [16:0]        y2_r, y2_nxt;
  logic [16:0]        smn2_r, smn2_nxt;
  logic [17:0]        smx2_r, smx2_nxt;
  logic signed [15:0] n_ext;
  logic signed [9:0]  hfac;
  logic signed [17:0] hfac_ext;

  always_comb begin
    n_ext    = {{7{n1_r[8]}}, n1_r};
    x2_nxt   = (n_ext <<< 6) - (n_ext <<< 2) + $signed({8'd0, d1_r});
    hp2_nxt  = 18'({1'b0, cfg.hue_max} + 9'd1) * 18'({d1_r, 1'b0});
    hfac     = $signed({2'b00, cfg.hue_max}) - spc_pkg::HueWrap;
    hfac_ext = {{8{hfac[9]}}, hfac};
    hn2_nxt  = hfac_ext * $signed({9'd0, d1_r, 1'b0});
    y2_nxt   = 17'(d1_r) * 17'd510 + 17'(r1_r);
    smn2_nxt = 17'(cfg.sat_min) * 17'({r1_r, 1'b0});
    smx2_nxt = 18'({1'b0, cfg.sat_max} + 9'd1) * 18'({r1_r, 1'b0});
  end

  // stage 3 (result register)
  logic               v3_r;
  logic               skin3_r, skin3_nxt;
  logic signed [18:0] x_s, hp_s, hn_s;
  logic               hue_ok;

  always_comb begin
    x_s       = {{3{x2_r[15]}}, x2_r};
    hp_s      = {1'b0, hp2_r};
    hn_s      = {hn2_r[17], hn2_r};
    hue_ok    = x2_r[15] ? (x_s < hn_s) : (x_s < hp_s);
    skin3_nxt = ok2_r && hue_ok && (y2_r >= smn2_r) && ({1'b0, y2_r} < smx2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v1_nxt;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok1_r   <= ok1_nxt;
      d1_r    <= d1_nxt;
      n1_r    <= n1_nxt;
      r1_r    <= red;
      ok2_r   <= ok1_r;
      x2_r    <= x2_nxt;
      hp2_r   <= hp2_nxt;
      hn2_r   <= hn2_nxt;
      y2_r    <= y2_nxt;
      smn2_r  <= smn2_nxt;
      smx2_r  <= smx2_nxt;
      skin3_r <= skin3_nxt;
    end
  end

  assign res_valid = v3_r;
  assign is_skin   = skin3_r;

endmodule

// ===== rtl/core/skin_pixel_classifier.sv =====
`timescale 1ns / 1ps
// Skin pixel classifier top: config registers, input skid, output handshake.
// Depends on spc_pkg and spc_datapath.
//
//  port group | dir | width | contents
//  in_*       | in  | 24    | word: blue, green, red
//  out_*      | out | 8     | word: is_skin
//  cfg_*      | in  | 3 + 8 | register write, no read-back
//
// out_tvalid comes from the last of three register stages, the first loaded when the
// word enters the pipeline; one word per cycle sustained while out_tready is high,
// through the three-stage pipeline in spc_datapath.
// Reset clears valid bits and loads register defaults.
// A stall on out_tready freezes the pipeline; one input word parks in the
// skid register, so in_tready is a registered signal.
module skin_pixel_classifier (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [spc_pkg::InDw-1:0]    in_tdata,   // [7:0] blue, [15:8] green, [23:16] red
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [spc_pkg::OutDw-1:0]   out_tdata,  // [0] is_skin, rest zero
  input  logic                        cfg_wr_en,
  input  logic [spc_pkg::CfgAw-1:0]   cfg_addr,
  input  logic [spc_pkg::PixW-1:0]    cfg_wdata
);

  spc_pkg::spc_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_addr)
        spc_pkg::REG_BLUE_MIN:  cfg_nxt.blue_min      = cfg_wdata;
        spc_pkg::REG_GREEN_MIN: cfg_nxt.green_min     = cfg_wdata;
        spc_pkg::REG_RED_MIN:   cfg_nxt.red_min       = cfg_wdata;
        spc_pkg::REG_RG_GAP:    cfg_nxt.red_green_gap = cfg_wdata;
        spc_pkg::REG_HUE_MAX:   cfg_nxt.hue_max       = cfg_wdata;
        spc_pkg::REG_SAT_MIN:   cfg_nxt.sat_min       = cfg_wdata;
        spc_pkg::REG_SAT_MAX:   cfg_nxt.sat_max       = cfg_wdata;
        default:                cfg_nxt               = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blue_min      <= spc_pkg::BlueMinRst;
      cfg_r.green_min     <= spc_pkg::GreenMinRst;
      cfg_r.red_min       <= spc_pkg::RedMinRst;
      cfg_r.red_green_gap <= spc_pkg::RgGapRst;
      cfg_r.hue_max       <= spc_pkg::HueMaxRst;
      cfg_r.sat_min       <= spc_pkg::SatMinRst;
      cfg_r.sat_max       <= spc_pkg::SatMaxRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input skid
  logic                       skid_vld_r, skid_vld_nxt;
  logic [spc_pkg::InDw-1:0]   skid_data_r;
  logic                       adv;
  logic                       src_valid;
  logic [spc_pkg::InDw-1:0]   src_data;
  logic                       res_valid;
  logic                       is_skin;

  assign adv       = !res_valid || out_tready;
  assign in_tready = !skid_vld_r;
  assign src_valid = skid_vld_r || in_tvalid;
  assign src_data  = skid_vld_r ? skid_data_r : in_tdata;

  always_comb begin
    skid_vld_nxt = skid_vld_r;
    if (adv) begin
      skid_vld_nxt = 1'b0;
    end else if (in_tvalid && in_tready) begin
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else begin
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_tvalid && in_tready) begin
      skid_data_r <= in_tdata;
    end
  end

  spc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .src_valid (src_valid),
    .blue      (src_data[7:0]),
    .green     (src_data[15:8]),
    .red       (src_data[23:16]),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .is_skin   (is_skin)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {7'd0, is_skin};

endmodule

// ===== test/skin_pixel_classifier_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for skin_pixel_classifier: streams BGR pixels, predicts each skin mark.
// Depends on spc_pkg and the classifier RTL.
module skin_pixel_classifier_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam logic [spc_pkg::CfgAw-1:0] RegUnmapped = 3'd7;

  typedef struct packed {
    logic [spc_pkg::PixW-1:0] red;
    logic [spc_pkg::PixW-1:0] green;
    logic [spc_pkg::PixW-1:0] blue;
  } pixel_t;

  typedef struct {
    pixel_t px;
    bit     skin;
  } verdict_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [spc_pkg::InDw-1:0]   in_tdata = '0;   // [7:0] blue, [15:8] green, [23:16] red
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [spc_pkg::OutDw-1:0]  out_tdata;       // [0] is_skin, [7:1] zero
  logic                       cfg_wr_en = 1'b0;
  logic [spc_pkg::CfgAw-1:0]  cfg_addr = '0;
  logic [spc_pkg::PixW-1:0]   cfg_wdata = '0;

  pixel_t      pixel_q[$];
  verdict_t    verdict_q[$];
  logic [7:0]  thr_shadow [0:6];
  int          pixels_issued = 0;
  int          pixels_accepted = 0;
  int          results_seen = 0;
  int          skin_count = 0;
  int          fail_count = 0;
  int          settings_used = 1;
  int          in_gap = 0;
  int          out_wait = 0;
  int          in_gap_max = 0;
  int          out_gap_max = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned cycle_count = 0;

  skin_pixel_classifier uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit classify_skin(pixel_t px);
    int b, g, r, mx, mn, d, n, num, den, hue, sat;
    bit ok;
    b = px.blue;
    g = px.green;
    r = px.red;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    sat = (mx == 0) ? 0 : (510 * d + mx) / (2 * mx);
    hue = 0;
    if (d != 0) begin
      if (mx == r) n = g - b;
      else if (mx == g) n = b - r + 2 * d;
      else n = r - g + 4 * d;
      num = 60 * n + d;
      den = 2 * d;
      hue = (num >= 0) ? num / den : -((-num + den - 1) / den);
      if (hue < 0) hue += 180;
    end
    ok = b >= thr_shadow[spc_pkg::REG_BLUE_MIN] && g >= thr_shadow[spc_pkg::REG_GREEN_MIN] &&
         r >= thr_shadow[spc_pkg::REG_RED_MIN];
    ok = ok && r > g && r > b && (r - g) > thr_shadow[spc_pkg::REG_RG_GAP];
    ok = ok && hue <= thr_shadow[spc_pkg::REG_HUE_MAX] &&
         sat >= thr_shadow[spc_pkg::REG_SAT_MIN] && sat <= thr_shadow[spc_pkg::REG_SAT_MAX];
    return ok;
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    int kind;
    kind = $urandom_range(0, 9);
    p = pixel_t'(24'($urandom));
    if (kind < 4) begin
      p.red   = 8'($urandom_range(60, 255));
      p.green = 8'($urandom_range(0, p.red));
      p.blue  = 8'($urandom_range(0, p.red));
    end else if (kind == 4) begin
      case ($urandom_range(0, 3))
        0: p.green = p.red;
        1: p.blue  = p.red;
        2: p.blue  = p.green;
        default: begin
          p.green = p.red;
          p.blue  = p.red;
        end
      endcase
    end
    return p;
  endfunction

  task automatic report_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH: %s", msg);
  endtask

  task automatic push_pixel(int b, int g, int r);
    pixel_t p;
    p.blue  = 8'(b);
    p.green = 8'(g);
    p.red   = 8'(r);
    pixel_q.insert(pixel_q.size(), p);
    pixels_issued++;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (results_seen < pixels_issued);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic [spc_pkg::CfgAw-1:0] idx, logic [spc_pkg::PixW-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx <= spc_pkg::REG_SAT_MAX) thr_shadow[idx] = val;
  endtask

  task automatic set_thresholds(int bmin, int gmin, int rmin, int gap,
                                int hmax, int smin, int smax);
    wait_drained();
    write_reg(spc_pkg::REG_BLUE_MIN,  8'(bmin));
    write_reg(spc_pkg::REG_GREEN_MIN, 8'(gmin));
    write_reg(spc_pkg::REG_RED_MIN,   8'(rmin));
    write_reg(spc_pkg::REG_RG_GAP,    8'(gap));
    write_reg(spc_pkg::REG_HUE_MAX,   8'(hmax));
    write_reg(spc_pkg::REG_SAT_MIN,   8'(smin));
    write_reg(spc_pkg::REG_SAT_MAX,   8'(smax));
    write_reg(RegUnmapped,            8'hff);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // sender
  always @(posedge clk) begin
    verdict_t v;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        v.px   = pixel_t'(in_tdata);
        v.skin = classify_skin(pixel_t'(in_tdata));
        verdict_q.insert(verdict_q.size(), v);
        pixels_accepted++;
      end
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        in_tdata  <= pixel_q.pop_front();
        in_tvalid <= 1'b1;
        in_gap = $urandom_range(0, in_gap_max);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          report_failure($sformatf("unexpected word %h", out_tdata));
        end else begin
          want = verdict_q.pop_front();
          if (out_tdata[0] !== want.skin)
            report_failure($sformatf("pixel b=%0d g=%0d r=%0d is_skin exp %0d got %b",
                                     want.px.blue, want.px.green, want.px.red,
                                     want.skin, out_tdata[0]));
          if (out_tdata[spc_pkg::OutDw-1:1] !== '0)
            report_failure($sformatf("padding exp 0 got %h",
                                     out_tdata[spc_pkg::OutDw-1:1]));
          if (want.skin) skin_count++;
        end
        out_wait = $urandom_range(0, out_gap_max);
      end else if (out_wait > 0) begin
        out_wait--;
      end
      out_tready <= (out_wait == 0) && (hold_left == 0);
    end
  end

  // one long back-pressure stretch so the pipeline fills and in_tready drops
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && pixels_accepted >= 400) begin
      hold_left <= 160;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    thr_shadow[spc_pkg::REG_BLUE_MIN]  = spc_pkg::BlueMinRst;
    thr_shadow[spc_pkg::REG_GREEN_MIN] = spc_pkg::GreenMinRst;
    thr_shadow[spc_pkg::REG_RED_MIN]   = spc_pkg::RedMinRst;
    thr_shadow[spc_pkg::REG_RG_GAP]    = spc_pkg::RgGapRst;
    thr_shadow[spc_pkg::REG_HUE_MAX]   = spc_pkg::HueMaxRst;
    thr_shadow[spc_pkg::REG_SAT_MIN]   = spc_pkg::SatMinRst;
    thr_shadow[spc_pkg::REG_SAT_MAX]   = spc_pkg::SatMaxRst;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset thresholds: extremes, ties, a typical skin tone
    push_pixel(0, 0, 0);
    push_pixel(255, 255, 255);
    push_pixel(0, 0, 255);
    push_pixel(0, 255, 0);
    push_pixel(255, 0, 0);
    push_pixel(50, 200, 200);
    push_pixel(200, 200, 50);
    push_pixel(200, 50, 200);
    push_pixel(100, 130, 200);
    push_pixel(20, 40, 95);
    push_pixel(120, 100, 200);
    push_pixel(60, 80, 160);

    // wrapped hues around 173..179
    set_thresholds(0, 0, 0, 0, 173, 0, 255);
    push_pixel(120, 100, 200);
    push_pixel(122, 100, 200);
    push_pixel(101, 100, 120);
    push_pixel(100, 130, 200);
    wait_drained();
    write_reg(spc_pkg::REG_HUE_MAX, 8'd179);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    push_pixel(101, 100, 120);
    push_pixel(120, 100, 200);

    set_thresholds(0, 0, 0, 0, 180, 200, 100);
    push_pixel(100, 130, 200);
    push_pixel(0, 0, 255);

    set_thresholds(255, 255, 255, 255, 255, 255, 255);
    push_pixel(255, 255, 255);
    push_pixel(0, 0, 255);

    set_thresholds(0, 0, 0, 0, 0, 0, 0);
    push_pixel(0, 0, 255);
    push_pixel(0, 0, 1);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_thresholds(spc_pkg::BlueMinRst, spc_pkg::GreenMinRst, spc_pkg::RedMinRst,
                          spc_pkg::RgGapRst, spc_pkg::HueMaxRst, spc_pkg::SatMinRst,
                          spc_pkg::SatMaxRst);
        7: set_thresholds(0, 0, 0, 0, 180, 0, 255);
        default: set_thresholds($urandom_range(0, 120), $urandom_range(0, 120),
                                $urandom_range(0, 160), $urandom_range(0, 60),
                                ($urandom_range(0, 3) == 0) ? $urandom_range(170, 255)
                                                            : $urandom_range(0, 40),
                                $urandom_range(0, 100), $urandom_range(100, 255));
      endcase
      in_gap_max  = (ph % 2 == 1) ? 7 : 0;
      out_gap_max = (ph % 4 >= 2) ? 7 : 0;
      for (int k = 0; k < 150; k++) begin
        pixel_q.insert(pixel_q.size(), rand_pixel());
        pixels_issued++;
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (verdict_q.size() != 0)
      report_failure($sformatf("%0d expected words never arrived", verdict_q.size()));
    $display("Classified %0d pixels under %0d threshold settings; %0d marked skin.",
             results_seen, settings_used, skin_count);
    $display("Random gaps on both sides plus one %0d-cycle output stall; %0d mismatches.",
             160, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
